FILE: rtl/mhic_pkg.sv
`default_nettype none

package mhic_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TS_W        = 32;
  localparam int DUR_W       = 16;
  localparam int PCT_W       = 7;
  localparam int MS_PER_S    = 1000;
  localparam int PCT_FULL    = 100;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register byte addresses, bit 2 upwards selects the register
  localparam logic [APB_AW-1:0] REG_CAL_DURATION = 3'h0;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_e;

  typedef struct packed {
    logic clear;
    logic fold;
    logic commit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/mhic_axis_lane.sv
`default_nettype none

module mhic_axis_lane #(
  parameter int SAMPLE_BITS = mhic_pkg::SAMPLE_BITS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire mhic_pkg::lane_ctrl_t    ctrl_i,
  input  wire                          is_sample_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS:0]  corrected_o
);

  localparam logic signed [SAMPLE_BITS-1:0] MinInit = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MaxInit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] min_q, max_q, offset_q;
  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS:0]   sample_ext, offset_ext;

  // floor((max+min)/2) is the arithmetic shift of the widened sum
  assign sum        = {max_q[SAMPLE_BITS-1], max_q} + {min_q[SAMPLE_BITS-1], min_q};
  assign sample_ext = {sample_i[SAMPLE_BITS-1], sample_i};
  assign offset_ext = {offset_q[SAMPLE_BITS-1], offset_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MinInit;
      max_q    <= MaxInit;
      offset_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        min_q <= MinInit;
        max_q <= MaxInit;
      end else if (ctrl_i.fold) begin
        if (sample_i < min_q) begin
          min_q <= sample_i;
        end
        if (sample_i > max_q) begin
          max_q <= sample_i;
        end
      end
      if (ctrl_i.commit) begin
        offset_q <= sum[SAMPLE_BITS:1];
      end
    end
  end

  assign corrected_o = is_sample_i ? sample_ext - offset_ext : '0;

endmodule

`default_nettype wire

FILE: rtl/mhic_pct_div.sv
`default_nettype none

// Restoring divider for a quotient known to fit in PCT_W bits; one bit a cycle.
module mhic_pct_div (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         start_i,
  input  wire  [mhic_pkg::TS_W+mhic_pkg::PCT_W-1:0]   num_i,
  input  wire  [mhic_pkg::TS_W-1:0]                   den_i,
  output logic                                        done_o,
  output logic [mhic_pkg::PCT_W-1:0]                  quot_o
);

  localparam int QW   = mhic_pkg::PCT_W;
  localparam int NumW = mhic_pkg::TS_W + QW;
  localparam int DenW = NumW - 1;
  localparam int CntW = $clog2(QW);
  localparam logic [CntW-1:0] LastStep = CntW'(QW - 1);

  logic [NumW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            ge;

  assign ge = rem_q >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= {den_i, {(QW-1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - {1'b0, den_q};
      end
      den_q  <= den_q >> 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: rtl/mag_hard_iron_calibration.sv
`default_nettype none

// Hard-iron calibration of a three-axis magnetometer by per-axis min/max tracking.
// Input stream: tuser carries the operation (sample, start, stop), tdata the three
// raw axis counts and a millisecond timestamp. Each input transaction yields exactly
// one output transaction: the corrected axes, the window progress in percent, and in
// tuser the calibrating flag and a strobe marking that new offsets were stored.
// The three axes run in parallel lanes; a merge stage packs their results with the
// progress figure into the output register.
// After acceptance an item passes S_UPD and S_COMMIT, then S_DIV with the 7-step
// progress divider when a division is needed (not idle, window not yet elapsed),
// and S_OUT, which loads the output register. One item is processed at a time: no
// new item is accepted until the previous one has been loaded into that register.
// A new item may be accepted while the previous result still waits in the output
// register; if the receiver stalls, the block holds its finished result and waits
// before loading the output register again.
// Reset clears the window, loads the extremes with their limits, zeroes the offsets
// and sets cal_duration_s to 1. cal_duration_s sits at APB byte address 0.
module mag_hard_iron_calibration #(
  parameter int SAMPLE_BITS = mhic_pkg::SAMPLE_BITS
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // APB configuration
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [mhic_pkg::APB_AW-1:0]            paddr,
  input  wire  [mhic_pkg::APB_DW-1:0]            pwdata,
  output logic [mhic_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready,
  // input stream
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // mag_x, mag_y, mag_z, now_ms
  input  wire  [((3*SAMPLE_BITS+mhic_pkg::TS_W+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  wire  [1:0]                             s_axis_tuser,
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // corrected_x, corrected_y, corrected_z, progress_pct
  output logic [((3*(SAMPLE_BITS+1)+mhic_pkg::PCT_W+7)/8)*8-1:0] m_axis_tdata,
  // calibrating, offsets_committed
  output logic [1:0]                             m_axis_tuser
);

  localparam int TsW  = mhic_pkg::TS_W;
  localparam int DurW = mhic_pkg::DUR_W;
  localparam int PctW = mhic_pkg::PCT_W;
  localparam int NumW = TsW + PctW;
  localparam int OutW = ((3*(SAMPLE_BITS+1)+PctW+7)/8)*8;
  localparam int CorW = SAMPLE_BITS + 1;
  localparam logic [PctW-1:0] PctFull = PctW'(mhic_pkg::PCT_FULL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_COMMIT,
    S_DIV,
    S_OUT
  } state_e;

  state_e                  state_q;
  mhic_pkg::op_e           op_q;
  logic [SAMPLE_BITS-1:0]  mag_q [3];
  logic [TsW-1:0]          now_q;
  logic [TsW-1:0]          start_q;
  logic [TsW-1:0]          len_q;
  logic [TsW-1:0]          elapsed_q;
  logic [DurW-1:0]         dur_q;
  logic                    active_q;
  logic                    seen_q;
  logic                    commit_q;
  logic [PctW-1:0]         pct_q;
  logic                    out_valid_q;
  logic [OutW-1:0]         out_data_q;
  logic [1:0]              out_user_q;

  logic                    in_accept;
  logic                    cfg_write;
  logic                    out_free;
  logic [TsW-1:0]          elapsed;
  logic [DurW-1:0]         dur_eff;
  logic [TsW-1:0]          len_new;
  logic                    div_start;
  logic                    div_done;
  logic [PctW-1:0]         div_quot;
  logic [NumW-1:0]         div_num;
  logic                    is_sample;
  mhic_pkg::lane_ctrl_t    lane_ctrl;
  logic [CorW-1:0]         corrected [3];
  logic [OutW-1:0]         out_data;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[mhic_pkg::APB_AW-1:2] == mhic_pkg::REG_CAL_DURATION[mhic_pkg::APB_AW-1:2]) begin
      prdata[DurW-1:0] = dur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DurW'(1);
    end else if (cfg_write &&
                 paddr[mhic_pkg::APB_AW-1:2] ==
                 mhic_pkg::REG_CAL_DURATION[mhic_pkg::APB_AW-1:2]) begin
      dur_q <= pwdata[DurW-1:0];
    end
  end

  // ---------------- control ----------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign elapsed  = now_q - start_q;
  assign dur_eff  = (dur_q == '0) ? DurW'(1) : dur_q;
  assign len_new  = TsW'(dur_eff) * TsW'(mhic_pkg::MS_PER_S);
  assign div_num  = NumW'(elapsed_q) * NumW'(mhic_pkg::PCT_FULL);
  assign div_start = (state_q == S_COMMIT) && active_q && (elapsed_q < len_q);

  assign is_sample        = (op_q == mhic_pkg::OP_SAMPLE);
  assign lane_ctrl.clear  = (state_q == S_UPD) && (op_q == mhic_pkg::OP_START);
  assign lane_ctrl.fold   = (state_q == S_UPD) && is_sample && active_q;
  assign lane_ctrl.commit = (state_q == S_COMMIT) && commit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      seen_q      <= 1'b0;
      commit_q    <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      // in S_OUT the load below decides the valid flag
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            commit_q <= 1'b0;
            state_q  <= S_UPD;
          end
        end
        S_UPD: begin
          case (op_q)
            mhic_pkg::OP_SAMPLE: begin
              if (active_q) begin
                seen_q <= 1'b1;
                if (elapsed >= len_q) begin
                  active_q <= 1'b0;
                  commit_q <= 1'b1;
                end
              end
            end
            mhic_pkg::OP_START: begin
              active_q <= 1'b1;
              start_q  <= now_q;
              len_q    <= len_new;
              seen_q   <= 1'b0;
            end
            mhic_pkg::OP_STOP: begin
              if (active_q) begin
                active_q <= 1'b0;
                commit_q <= seen_q;
              end
            end
            default: begin
            end
          endcase
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          // the window state is final here; pick the progress figure
          if (div_start) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= out_data;
            out_user_q  <= {commit_q, active_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= mhic_pkg::op_e'(s_axis_tuser);
      mag_q[0] <= s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
      mag_q[1] <= s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
      mag_q[2] <= s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
      now_q    <= s_axis_tdata[3*SAMPLE_BITS +: TsW];
    end
    if (state_q == S_UPD) begin
      elapsed_q <= (op_q == mhic_pkg::OP_START) ? '0 : elapsed;
    end
    if (state_q == S_COMMIT) begin
      pct_q <= active_q ? PctFull : '0;
    end else if (state_q == S_DIV && div_done) begin
      pct_q <= div_quot;
    end
  end

  // ---------------- axis lanes ----------------
  for (genvar a = 0; a < 3; a++) begin : g_lane
    mhic_axis_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl),
      .is_sample_i (is_sample),
      .sample_i    (mag_q[a]),
      .corrected_o (corrected[a])
    );
  end

  mhic_pct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------- merge ----------------
  always_comb begin
    out_data = '0;
    out_data[0*CorW +: CorW] = corrected[0];
    out_data[1*CorW +: CorW] = corrected[1];
    out_data[2*CorW +: CorW] = corrected[2];
    out_data[3*CorW +: PctW] = pct_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: rtl/mhic_checker.sv
`default_nettype none

module mhic_checker #(
  parameter int SAMPLE_BITS = mhic_pkg::SAMPLE_BITS
) (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    s_axis_tvalid,
  input wire                                    s_axis_tready,
  input wire                                    m_axis_tvalid,
  input wire                                    m_axis_tready,
  input wire [((3*(SAMPLE_BITS+1)+mhic_pkg::PCT_W+7)/8)*8-1:0] m_axis_tdata,
  input wire [1:0]                              m_axis_tuser
);

  localparam int PctW = mhic_pkg::PCT_W;
  localparam int PctLo = 3*(SAMPLE_BITS+1);
  localparam logic [PctW-1:0] PctFull = PctW'(mhic_pkg::PCT_FULL);

  logic [PctW-1:0] pct;
  assign pct = m_axis_tdata[PctLo +: PctW];

  // one item in flight: no second acceptance straight after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  a_commit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && pct == '0)
    else $error("commit reported with window still open");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pct <= PctFull)
    else $error("progress above full scale");

  a_idle_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> pct == '0)
    else $error("progress reported while not calibrating");

endmodule

bind mag_hard_iron_calibration mhic_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mhic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD  = 10;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          LONG_HOLD   = 300;
  localparam logic [1:0]  OP_RESERVED = 2'd3;

  // one output transaction as the block should report it
  typedef struct packed {
    logic [2:0][16:0] corr;
    logic             calibrating;
    logic [6:0]       pct;
    logic             committed;
  } cal_result_t;

  class cal_scoreboard;
    logic [15:0]       dur_s;
    bit                active;
    bit                seen;
    logic [31:0]       win_start;
    logic [31:0]       win_end;
    logic [2:0][15:0]  lo;
    logic [2:0][15:0]  hi;
    logic [2:0][15:0]  offs;
    cal_result_t       expq[$];
    int unsigned       errors;

    function new();
      dur_s     = 16'd1;
      active    = 1'b0;
      seen      = 1'b0;
      win_start = '0;
      win_end   = '0;
      offs      = '0;
      errors    = 0;
      clear_extremes();
    endfunction

    function void clear_extremes();
      int a;
      for (a = 0; a < 3; a++) begin
        lo[a] = 16'h7FFF;
        hi[a] = 16'h8000;
      end
    endfunction

    function void commit_offsets();
      int a;
      logic signed [16:0] sum;
      for (a = 0; a < 3; a++) begin
        sum     = $signed(hi[a]) + $signed(lo[a]);
        offs[a] = sum[16:1];  // arithmetic halving rounds towards minus infinity
      end
    endfunction

    function logic [6:0] progress_at(logic [31:0] now);
      logic [31:0] span;
      logic [31:0] elapsed;
      logic [63:0] scaled;
      if (!active) return 7'd0;
      span    = win_end - win_start;
      elapsed = now - win_start;
      if (span == 0 || elapsed >= span) return 7'(mhic_pkg::PCT_FULL);
      scaled = {32'd0, elapsed} * 64'(mhic_pkg::PCT_FULL);
      return 7'(scaled / {32'd0, span});
    endfunction

    function int unsigned pending();
      return expq.size();
    endfunction

    function void note_input(logic [1:0] op, logic [47:0] mag, logic [31:0] now);
      cal_result_t        r;
      logic signed [15:0] s;
      logic [15:0]        secs;
      int                 a;
      r = '0;
      if (op == mhic_pkg::OP_SAMPLE) begin
        if (active) begin
          for (a = 0; a < 3; a++) begin
            s = $signed(mag[16*a +: 16]);
            if (s < $signed(lo[a])) lo[a] = s;
            if (s > $signed(hi[a])) hi[a] = s;
          end
          seen = 1'b1;
          if (now - win_start >= win_end - win_start) begin
            active = 1'b0;
            commit_offsets();
            r.committed = 1'b1;
          end
        end
        for (a = 0; a < 3; a++)
          r.corr[a] = $signed(mag[16*a +: 16]) - $signed(offs[a]);
      end else if (op == mhic_pkg::OP_START) begin
        secs      = (dur_s == 16'd0) ? 16'd1 : dur_s;
        active    = 1'b1;
        win_start = now;
        win_end   = now + secs * mhic_pkg::MS_PER_S;
        seen      = 1'b0;
        clear_extremes();
      end else if (op == mhic_pkg::OP_STOP) begin
        if (active) begin
          active = 1'b0;
          if (seen) begin
            commit_offsets();
            r.committed = 1'b1;
          end
        end
      end
      r.calibrating = active;
      r.pct         = progress_at(now);
      expq.push_back(r);
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] user);
      cal_result_t want;
      cal_result_t got;
      string       name;
      int          a;
      got.corr[0]     = data[16:0];
      got.corr[1]     = data[33:17];
      got.corr[2]     = data[50:34];
      got.pct         = data[57:51];
      got.calibrating = user[0];
      got.committed   = user[1];
      if (expq.size() == 0) begin
        $error("unexpected output transaction, data %h user %b", data, user);
        errors++;
        return;
      end
      want = expq.pop_front();
      for (a = 0; a < 3; a++) begin
        name = (a == 0) ? "corrected_x" : (a == 1) ? "corrected_y" : "corrected_z";
        if (got.corr[a] !== want.corr[a]) begin
          $error("%s: expected %0d, got %0d", name, $signed(want.corr[a]),
                 $signed(got.corr[a]));
          errors++;
        end
      end
      if (got.calibrating !== want.calibrating) begin
        $error("calibrating: expected %0d, got %0d", want.calibrating, got.calibrating);
        errors++;
      end
      if (got.pct !== want.pct) begin
        $error("progress_pct: expected %0d, got %0d", want.pct, got.pct);
        errors++;
      end
      if (got.committed !== want.committed) begin
        $error("offsets_committed: expected %0d, got %0d", want.committed, got.committed);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [mhic_pkg::APB_AW-1:0]   paddr    = '0;
  logic [mhic_pkg::APB_DW-1:0]   pwdata   = '0;
  logic [mhic_pkg::APB_DW-1:0]   prdata;
  logic                          pready;
  logic                          s_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [79:0]                   s_tdata  = '0;   // mag_x, mag_y, mag_z, now_ms
  logic [1:0]                    s_tuser  = '0;   // operation
  logic                          m_axis_tvalid;
  logic                          m_tready = 1'b0;
  logic [63:0]                   m_axis_tdata;    // corrected_x/y/z, progress_pct
  logic [1:0]                    m_axis_tuser;    // calibrating, offsets_committed

  cal_scoreboard sb = new();
  int unsigned   burst_left = 0;
  bit            soak_armed = 1'b0;
  int unsigned   cycle_cnt  = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mag_hard_iron_calibration u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver: runs of ready, stall, toggling and noise; one long hold-off
  initial begin : sink
    int unsigned mode;
    int unsigned run_len;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (soak_armed && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(1, 30);
      repeat (run_len) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'b0;
          2: m_tready <= ~m_tready;
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic apb_write(input logic [mhic_pkg::APB_AW-1:0] addr,
                           input logic [mhic_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender paces itself in bursts; valid stays up between back-to-back transactions
  task automatic send_item(input logic [1:0] op, input logic [47:0] mag,
                           input logic [31:0] now);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {now, mag};
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, mag, now);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] secs);
    s_tvalid <= 1'b0;
    drain();
    apb_write(mhic_pkg::REG_CAL_DURATION, mhic_pkg::APB_DW'(secs));
    sb.dur_s = secs;
  endtask

  function automatic logic [47:0] any_mag();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] mag3(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // mostly clustered around a centre so offsets mean something, some wild values
  function automatic logic [15:0] axis_val(input int centre, input int spread);
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    return 16'(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic run_sessions(input int unsigned n_items);
    int unsigned done_cnt;
    int unsigned n_samp;
    int unsigned step_max;
    int unsigned win_ms;
    int          spread;
    int          cx;
    int          cy;
    int          cz;
    int unsigned k;
    logic [31:0] t;
    done_cnt = 0;
    t        = $urandom();
    win_ms   = ((sb.dur_s == 16'd0) ? 1 : int'(sb.dur_s)) * mhic_pkg::MS_PER_S;
    while (done_cnt < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), any_mag(), $urandom());
        done_cnt++;
      end else begin
        if ($urandom_range(0, 1) == 0) t = $urandom();
        n_samp   = $urandom_range(1, 10);
        step_max = win_ms * 2 / n_samp;
        spread   = $urandom_range(0, 2000);
        cx       = int'($urandom_range(0, 65535)) - 32768;
        cy       = int'($urandom_range(0, 65535)) - 32768;
        cz       = int'($urandom_range(0, 65535)) - 32768;
        send_item(mhic_pkg::OP_START, any_mag(), t);
        done_cnt++;
        for (k = 0; k < n_samp; k++) begin
          t += $urandom_range(0, step_max);
          if ($urandom_range(0, 7) == 0)
            send_item(OP_RESERVED, any_mag(), t);
          else if ($urandom_range(0, 24) == 0)
            send_item(mhic_pkg::OP_START, any_mag(), t);
          else
            send_item(mhic_pkg::OP_SAMPLE,
                      {axis_val(cz, spread), axis_val(cy, spread), axis_val(cx, spread)}, t);
          done_cnt++;
        end
        if ($urandom_range(0, 2) == 0) begin
          t += $urandom_range(0, step_max);
          send_item(mhic_pkg::OP_STOP, any_mag(), t);
          done_cnt++;
        end
        repeat ($urandom_range(0, 3)) begin
          t += $urandom_range(0, step_max);
          send_item(mhic_pkg::OP_SAMPLE, any_mag(), t);
          done_cnt++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_secs [5];
    int          p;
    phase_secs[0] = 16'd0;
    phase_secs[1] = 16'd3;
    phase_secs[2] = 16'hFFFF;
    phase_secs[3] = 16'($urandom_range(2, 600));
    phase_secs[4] = 16'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, window of one second from reset
    send_item(mhic_pkg::OP_SAMPLE, mag3(32767, -32768, 0), 32'd5);
    send_item(mhic_pkg::OP_STOP,   any_mag(), 32'd10);          // stop while idle
    send_item(OP_RESERVED,         any_mag(), 32'd15);
    send_item(mhic_pkg::OP_START,  any_mag(), 32'd100);
    send_item(mhic_pkg::OP_STOP,   any_mag(), 32'd200);         // no sample seen, offsets kept
    send_item(mhic_pkg::OP_START,  any_mag(), 32'd300);
    send_item(mhic_pkg::OP_SAMPLE, mag3(-32768, 32767, 1234), 32'd400);
    send_item(OP_RESERVED,         any_mag(), 32'd600);
    send_item(mhic_pkg::OP_START,  any_mag(), 32'd700);         // restart while active
    send_item(mhic_pkg::OP_SAMPLE, mag3(100, -200, 300), 32'd800);
    send_item(mhic_pkg::OP_SAMPLE, mag3(-7, 51, -300), 32'd850);
    send_item(mhic_pkg::OP_STOP,   any_mag(), 32'd900);
    send_item(mhic_pkg::OP_SAMPLE, mag3(0, 0, 0), 32'd1000);
    send_item(mhic_pkg::OP_START,  any_mag(), 32'hFFFF_FE00);   // window across timestamp wrap
    send_item(mhic_pkg::OP_SAMPLE, mag3(-5, 7, 32767), 32'hFFFF_FF80);
    send_item(OP_RESERVED,         any_mag(), 32'h0000_0100);
    send_item(mhic_pkg::OP_SAMPLE, mag3(10, 20, -32768), 32'h0000_01F0);
    send_item(mhic_pkg::OP_SAMPLE, mag3(32767, 32767, 32767), 32'h0000_0200);
    send_item(mhic_pkg::OP_START,  any_mag(), 32'd5000);
    send_item(mhic_pkg::OP_SAMPLE, mag3(-32768, -32768, -32768), 32'd5500);
    send_item(OP_RESERVED,         any_mag(), 32'd6500);        // past end, full progress
    send_item(mhic_pkg::OP_STOP,   any_mag(), 32'd7000);
    send_item(mhic_pkg::OP_SAMPLE, mag3(32767, 32767, 32767), 32'd7100);
    send_item(mhic_pkg::OP_START,  any_mag(), 32'd8000);
    send_item(mhic_pkg::OP_SAMPLE, mag3(32767, 32767, 32767), 32'd9000);  // closes at end
    send_item(mhic_pkg::OP_SAMPLE, mag3(-32768, -32768, -32768), 32'd9001);

    for (p = 0; p < 5; p++) begin
      set_window(phase_secs[p]);
      soak_armed = 1'b1;
      run_sessions(145);
    end

    s_tvalid <= 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/mhic_pkg.sv
rtl/mhic_axis_lane.sv
rtl/mhic_pct_div.sv
rtl/mag_hard_iron_calibration.sv
rtl/mhic_checker.sv
verif/testbench.sv
